// ===== src/stu_pkg.sv =====
// Shared types and constants for the sine Taylor-series unit.
// Holds fixed-point widths, the pipeline word struct and the reciprocal table.
// No dependencies.
package stu_pkg;

   // Fixed-point format of angle and result (Q3.28).
   localparam int FRAC_BITS = 28;
   localparam int ANGLE_W   = 32;

   // Config register.
   localparam int CSR_W = 4;
   localparam logic [CSR_W-1:0] TERMS_RESET = 4'd3;

   // Internal widths. |x| <= 2^31 gives sq <= 2^34, every term below 2^37,
   // the sum below 2^41 and every series coefficient below 2^32.
   localparam int MAG_W  = 32;
   localparam int SQ_W   = 35;
   localparam int TERM_W = 38;
   localparam int COEF_W = 32;
   localparam int ACC_W  = 42;
   localparam int PROD_W = 64;

   // Round-half-up offsets for the three multiply kinds.
   localparam logic [PROD_W:0]          SQ_RND = (PROD_W+1)'(1) << (FRAC_BITS - 1);
   localparam logic [SQ_W+COEF_W-1:0]   C_RND  = (SQ_W+COEF_W)'(1) << (COEF_W - 1);
   localparam logic [TERM_W+COEF_W:0]   T_RND  = (TERM_W+COEF_W+1)'(1) << (FRAC_BITS - 1);

   // Output saturation limits in accumulator width, and the saturated output words.
   localparam logic signed [ACC_W-1:0] ACC_POS_LIMIT = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] ACC_NEG_LIMIT = -ACC_W'(64'sd2147483648);
   localparam logic [ANGLE_W-1:0]      SINE_POS_MAX  = 32'h7FFF_FFFF;
   localparam logic [ANGLE_W-1:0]      SINE_NEG_MAX  = 32'h8000_0000;

   // One pipeline word. Each stage uses the fields it needs.
   typedef struct packed {
      logic                      last_flag;
      logic                      neg;
      logic [CSR_W-1:0]          n;
      logic [SQ_W-1:0]           sq;
      logic [TERM_W-1:0]         term;
      logic [COEF_W-1:0]         c;
      logic signed [ACC_W-1:0]   acc;
      logic [PROD_W-1:0]         tpp_lo;
      logic [TERM_W-1:0]         tpp_hi;
      logic [PROD_W-1:0]         cpp_lo;
      logic [SQ_W-1:0]           cpp_hi;
   } stu_pipe_type;

   // Ratio constants R(k) = round(2^32 / ((2k)(2k+1))), Q0.32.
   function automatic logic [COEF_W-1:0] recip_const(input logic [3:0] k);
      case (k)
         4'd1:    recip_const = 32'd715827883;
         4'd2:    recip_const = 32'd214748365;
         4'd3:    recip_const = 32'd102261126;
         4'd4:    recip_const = 32'd59652324;
         4'd5:    recip_const = 32'd39045157;
         4'd6:    recip_const = 32'd27531842;
         4'd7:    recip_const = 32'd20452225;
         4'd8:    recip_const = 32'd15790321;
         4'd9:    recip_const = 32'd12558384;
         4'd10:   recip_const = 32'd10226113;
         4'd11:   recip_const = 32'd8488078;
         4'd12:   recip_const = 32'd7158279;
         default: recip_const = '0;
      endcase
   endfunction

endpackage

// ===== src/sine_taylor_series_unit.sv =====
// Sine by Maclaurin series, fully pipelined, one word per cycle while the output is not stalled.
// Depends on stu_pkg (widths, pipeline word struct, reciprocal table).
//
// Usage
//   req_ channel: req_angle (signed Q3.28 radians) and req_last_sample. A word
//   is taken at a rising edge with req_valid high and req_stall low.
//   rsp_ channel: rsp_sine_value (signed Q3.28, saturated) and rsp_last_result,
//   the copy of req_last_sample. Taken with rsp_valid high, rsp_stall low.
//   csr_: csr_write_enable / csr_write_data set extra_terms, the number of
//   series terms after x (values above MAX_TERMS act as MAX_TERMS). Write
//   only while the pipe is empty.
// Timing
//   One word per cycle sustained while rsp_stall stays low: every stage has
//   its own valid, and each term costs two stages (partial products, then
//   combine/round).
// Reset
//   Synchronous, active high. Clears all valids and sets extra_terms to 3.
// Backpressure
//   A stalled result sits in the output register. Stages behind it keep
//   moving until the pipe is full; only then is req_stall raised. Bubbles
//   are squeezed out, so no word is lost or repeated.
module sine_taylor_series_unit
   import stu_pkg::*;
#(
   parameter int MAX_TERMS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // input channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [ANGLE_W-1:0] req_angle,
   input  logic                      req_last_sample,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ANGLE_W-1:0] rsp_sine_value,
   output logic                      rsp_last_result,
   // config
   input  logic                      csr_write_enable,
   input  logic [CSR_W-1:0]          csr_write_data
);

   // Stage map:
   //   0        capture |x|, sign, flags, clamped term count
   //   1        x*x product
   //   2        round to sq, acc = |x|
   //   3        partial products for c1 = sq*R1
   //   4        combine c1
   //   3+2k     term k partial products, c(k+1) products, add term k-1
   //   4+2k     combine term k and c(k+1)
   //   5+2M     add the last term
   localparam int NUM_STAGES = 2 * MAX_TERMS + 6;
   localparam int LAST       = NUM_STAGES - 1;

   // ---------------------------------------------------------------
   // Stage functions
   // ---------------------------------------------------------------
   function automatic stu_pipe_type stage_capture(input logic [ANGLE_W-1:0] raw,
                                                  input logic last_flag,
                                                  input logic [CSR_W-1:0] n);
      stu_pipe_type r;
      logic [MAG_W-1:0] mag;
      r = '0;
      // Two's complement negate also gives 2^31 for the most negative angle.
      mag = raw[ANGLE_W-1] ? (~raw + 1'b1) : raw;
      r.term      = TERM_W'(mag);
      r.neg       = raw[ANGLE_W-1];
      r.last_flag = last_flag;
      r.n         = n;
      return r;
   endfunction

   function automatic stu_pipe_type stage_square(input stu_pipe_type p);
      stu_pipe_type r;
      r = p;
      r.tpp_lo = PROD_W'(p.term[MAG_W-1:0]) * PROD_W'(p.term[MAG_W-1:0]);
      return r;
   endfunction

   function automatic stu_pipe_type stage_sq_round(input stu_pipe_type p);
      stu_pipe_type r;
      logic [PROD_W:0] sum;
      r   = p;
      sum = (PROD_W+1)'(p.tpp_lo) + SQ_RND;
      r.sq  = sum[FRAC_BITS+SQ_W-1:FRAC_BITS];
      r.acc = signed'(ACC_W'(p.term));
      return r;
   endfunction

   // sq * R split at bit 32 of sq
   function automatic stu_pipe_type coef_products(input stu_pipe_type p,
                                                  input logic [COEF_W-1:0] recip);
      stu_pipe_type r;
      r = p;
      r.cpp_lo = PROD_W'(p.sq[31:0]) * PROD_W'(recip);
      r.cpp_hi = SQ_W'(p.sq[SQ_W-1:32]) * SQ_W'(recip);
      return r;
   endfunction

   function automatic logic [COEF_W-1:0] coef_combine(input stu_pipe_type p);
      logic [SQ_W+COEF_W-1:0] sum;
      sum = {p.cpp_hi, 32'b0} + (SQ_W+COEF_W)'(p.cpp_lo) + C_RND;
      return sum[COEF_W+31:32];
   endfunction

   function automatic stu_pipe_type stage_c1(input stu_pipe_type p);
      stu_pipe_type r;
      r   = p;
      r.c = coef_combine(p);
      return r;
   endfunction

   // add or subtract term j when 1 <= j <= n; odd j subtracts
   function automatic logic signed [ACC_W-1:0] acc_add(input logic signed [ACC_W-1:0] acc,
                                                       input logic [TERM_W-1:0] term,
                                                       input logic [3:0] j,
                                                       input logic [CSR_W-1:0] n);
      logic signed [ACC_W-1:0] t;
      t = signed'(ACC_W'(term));
      if (j != 4'd0 && j <= n) begin
         return j[0] ? (acc - t) : (acc + t);
      end
      return acc;
   endfunction

   function automatic stu_pipe_type stage_e(input stu_pipe_type p, input logic [3:0] k);
      stu_pipe_type r;
      r = coef_products(p, recip_const(k + 4'd1));
      r.tpp_lo = PROD_W'(p.term[31:0]) * PROD_W'(p.c);
      r.tpp_hi = TERM_W'(p.term[TERM_W-1:32]) * TERM_W'(p.c);
      r.acc    = acc_add(p.acc, p.term, k - 4'd1, p.n);
      return r;
   endfunction

   function automatic stu_pipe_type stage_f(input stu_pipe_type p);
      stu_pipe_type r;
      logic [TERM_W+COEF_W:0] sum;
      r   = p;
      sum = (TERM_W+COEF_W+1)'({p.tpp_hi, 32'b0}) + (TERM_W+COEF_W+1)'(p.tpp_lo) + T_RND;
      r.term = sum[FRAC_BITS+TERM_W-1:FRAC_BITS];
      r.c    = coef_combine(p);
      return r;
   endfunction

   function automatic stu_pipe_type stage_last(input stu_pipe_type p);
      stu_pipe_type r;
      r     = p;
      r.acc = acc_add(p.acc, p.term, 4'(MAX_TERMS), p.n);
      return r;
   endfunction

   function automatic logic [ANGLE_W-1:0] saturate(input stu_pipe_type p);
      logic signed [ACC_W-1:0] v;
      v = p.neg ? -p.acc : p.acc;
      if (v > ACC_POS_LIMIT) begin
         return SINE_POS_MAX;
      end else if (v < ACC_NEG_LIMIT) begin
         return SINE_NEG_MAX;
      end
      return v[ANGLE_W-1:0];
   endfunction

   // ---------------------------------------------------------------
   // Config register
   // ---------------------------------------------------------------
   logic [CSR_W-1:0] csr_terms_ff;
   logic [CSR_W-1:0] terms_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_terms_ff <= TERMS_RESET;
      end else if (csr_write_enable) begin
         csr_terms_ff <= csr_write_data;
      end
   end

   assign terms_clamped = (csr_terms_ff > CSR_W'(MAX_TERMS)) ? CSR_W'(MAX_TERMS) : csr_terms_ff;

   // ---------------------------------------------------------------
   // Pipeline
   // ---------------------------------------------------------------
   stu_pipe_type            pipe_ff [NUM_STAGES];
   stu_pipe_type            pipe_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]   valid_ff;
   logic [NUM_STAGES-1:0]   valid_in;
   logic [NUM_STAGES-1:0]   stage_ready;
   logic                    out_ready;

   logic                      rsp_valid_ff;
   logic [ANGLE_W-1:0]        rsp_sine_ff;
   logic                      rsp_last_ff;

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   // A stage may load when the output can move or some stage from here up is empty.
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_ready
      assign stage_ready[i] = out_ready || !(&valid_ff[LAST:i]);
   end

   assign valid_in = {valid_ff[LAST-1:0], req_valid};

   assign pipe_in[0] = stage_capture(req_angle, req_last_sample, terms_clamped);
   assign pipe_in[1] = stage_square(pipe_ff[0]);
   assign pipe_in[2] = stage_sq_round(pipe_ff[1]);
   assign pipe_in[3] = coef_products(pipe_ff[2], recip_const(4'd1));
   assign pipe_in[4] = stage_c1(pipe_ff[3]);

   for (genvar k = 1; k <= MAX_TERMS; k++) begin : g_term
      assign pipe_in[3+2*k] = stage_e(pipe_ff[2+2*k], 4'(k));
      assign pipe_in[4+2*k] = stage_f(pipe_ff[3+2*k]);
   end

   assign pipe_in[LAST] = stage_last(pipe_ff[LAST-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (stage_ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (stage_ready[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // ---------------------------------------------------------------
   // Output register: negate, saturate
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_sine_ff <= saturate(pipe_ff[LAST]);
         rsp_last_ff <= pipe_ff[LAST].last_flag;
      end
   end

   assign req_stall       = !stage_ready[0];
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sine_value  = signed'(rsp_sine_ff);
   assign rsp_last_result = rsp_last_ff;

endmodule

// ===== src/stu_checker.sv =====
// Port-level assertions for sine_taylor_series_unit, bound to the top level.
// Depends on stu_pkg for field widths.
module stu_checker
   import stu_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [ANGLE_W-1:0] rsp_sine_value,
   input logic                      rsp_last_result
);

   // result word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_sine_value) && $stable(rsp_last_result))
      else $error("rsp word changed under stall");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // input backs up only when a result waits at a stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without output backpressure");

endmodule

bind sine_taylor_series_unit stu_checker u_stu_checker (.*);

// ===== tb/sine_taylor_series_unit_tb.sv =====
// Self-checking testbench for sine_taylor_series_unit: directed and random angles
// against a bit-exact series predictor, under random and long output stalls.
// Depends on stu_pkg and the sine_taylor_series_unit RTL.
`timescale 1ns / 1ps

module sine_taylor_series_unit_tb;
   import stu_pkg::*;

   localparam int          CLK_PERIOD   = 8;
   localparam int          MAX_TERMS    = 8;
   // Pipe latency plus margin; used before config writes and at the end.
   localparam int          DRAIN_CYCLES = 2 * MAX_TERMS + 6 + 10;
   localparam int          HOLD_CYCLES  = 150;
   localparam int          PHASE_WORDS  = 56;

   localparam logic [63:0] MAG_TOP  = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam longint      ACC_TOP  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint      SINE_TOP = 64'sd2147483647;
   localparam longint      SINE_BOT = -64'sd2147483648;

   // Handy Q3.28 angles.
   localparam logic [31:0] Q_ONE     = 32'h1000_0000;
   localparam logic [31:0] Q_PI      = 32'h3243_F6A8;
   localparam logic [31:0] Q_HALF_PI = 32'h1921_FB54;

   typedef struct {
      logic signed [ANGLE_W-1:0] angle;
      logic signed [ANGLE_W-1:0] sine;
      logic                      last;
   } owed_sine_type;

   // Tracks the sines still owed by the block and checks each one as it leaves.
   class sine_tracker_type;
      owed_sine_type owed_q[$];
      int unsigned   term_cfg = TERMS_RESET;
      int unsigned   bad_count = 0;

      // (a*b + half) >> sh on magnitudes, capped
      function logic [63:0] round_mul(logic [63:0] a, logic [63:0] b, int unsigned sh);
         logic [127:0] full;
         full = ({64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1))) >> sh;
         return (full > {64'd0, MAG_TOP}) ? MAG_TOP : full[63:0];
      endfunction

      function logic signed [ANGLE_W-1:0] series_sine(logic signed [ANGLE_W-1:0] angle);
         logic [63:0]        mag;
         logic [63:0]        sq;
         logic [63:0]        term;
         logic [63:0]        coef;
         logic [63:0]        ratio;
         logic [63:0]        dk;
         logic signed [64:0] wide;
         longint             acc;
         longint             tval;
         int unsigned        n;
         bit                 neg;
         neg = angle[ANGLE_W-1];
         mag = neg ? 64'h1_0000_0000 - {32'd0, angle} : {32'd0, angle};
         n   = (term_cfg > MAX_TERMS) ? MAX_TERMS : term_cfg;
         sq  = round_mul(mag, mag, FRAC_BITS);
         term = mag;
         acc  = longint'(mag);
         for (int k = 1; k <= n; k++) begin
            dk    = 64'((2 * k) * (2 * k + 1));
            ratio = ((64'd1 << 32) + dk / 2) / dk;
            coef  = round_mul(sq, ratio, 32);
            term  = round_mul(term, coef, FRAC_BITS);
            tval  = longint'(term);
            if (k % 2 == 1) begin
               wide = 65'(acc) - 65'(tval);
            end else begin
               wide = 65'(acc) + 65'(tval);
            end
            if (wide > ACC_TOP) begin
               acc = ACC_TOP;
            end else if (wide < -ACC_TOP) begin
               acc = -ACC_TOP;
            end else begin
               acc = wide[63:0];
            end
         end
         if (neg) begin
            acc = -acc;
         end
         if (acc > SINE_TOP) begin
            return 32'sh7FFF_FFFF;
         end else if (acc < SINE_BOT) begin
            return 32'sh8000_0000;
         end
         return 32'(acc);
      endfunction

      function void take_angle(logic signed [ANGLE_W-1:0] angle, logic last);
         owed_sine_type rec;
         rec.angle = angle;
         rec.sine  = series_sine(angle);
         rec.last  = last;
         owed_q.push_back(rec);
      endfunction

      function void match_sine(logic signed [ANGLE_W-1:0] sine, logic last);
         owed_sine_type want;
         if (owed_q.size() == 0) begin
            bad_count++;
            if (bad_count <= 10) begin
               $display("%0t: unexpected word sine=%h last=%b", $realtime, sine, last);
            end
            return;
         end
         want = owed_q.pop_front();
         if (sine !== want.sine || last !== want.last) begin
            bad_count++;
            if (bad_count <= 10) begin
               $display("%0t: angle %h (terms %0d): expected sine=%h last=%b, got sine=%h last=%b",
                        $realtime, want.angle, term_cfg, want.sine, want.last, sine, last);
            end
         end
      endfunction

      function int unsigned owed();
         return owed_q.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // Clock, reset and block inputs; every input known from time zero.
   // ---------------------------------------------------------------------------
   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic signed [ANGLE_W-1:0] req_angle        = '0;
   logic                      req_last_sample  = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic signed [ANGLE_W-1:0] rsp_sine_value;
   logic                      rsp_last_result;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_W-1:0]          csr_write_data   = '0;

   // Idle rates in percent; the sender's is used by send_word, the receiver's
   // by the stall process below.
   int unsigned send_idle_pct = 7;
   int unsigned rcv_idle_pct  = 50;

   // Long hold-off handshake: the stimulus bumps hold_asks, the stall process
   // notices and counts the stretch out itself.
   int unsigned hold_asks = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   sine_tracker_type trk = new();

   always #(CLK_PERIOD / 2) clock = ~clock;

   sine_taylor_series_unit #(
      .MAX_TERMS (MAX_TERMS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_angle        (req_angle),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sine_value   (rsp_sine_value),
      .rsp_last_result  (rsp_last_result),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Output stall: random at rcv_idle_pct, or held high for a whole stretch
   // when asked, so the pipe fills and req_stall has to come up.
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
   end

   // Result monitor: values seen here are the ones settled before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         trk.match_sine(rsp_sine_value, rsp_last_result);
      end
   end

   // Offer one word, with random idle cycles ahead of it, and hold it until taken.
   task automatic send_word(input logic signed [ANGLE_W-1:0] angle, input logic last_flag);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_angle       <= angle;
      req_last_sample <= last_flag;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      trk.take_angle(angle, last_flag);
   endtask

   // Wait for all owed sines plus the pipe tail, then hold until drained.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (trk.owed() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // extra_terms write; only ever done with the pipe empty.
   task automatic set_terms(input logic [CSR_W-1:0] value);
      drain_pipe();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      trk.term_cfg = value;
   endtask

   // Random angle: half the time the useful range of +-pi, plus the whole format,
   // tiny magnitudes and the format corners.
   function automatic logic signed [ANGLE_W-1:0] pick_angle();
      int unsigned sel;
      logic [31:0] v;
      sel = $urandom_range(0, 9);
      if (sel <= 4) begin
         v = 32'($urandom_range(0, 2 * Q_PI)) - Q_PI;
      end else if (sel <= 7) begin
         v = $urandom;
      end else if (sel == 8) begin
         v = 32'($urandom_range(0, 2047));
         if ($urandom_range(0, 1) == 1) begin
            v = -v;
         end
      end else begin
         case ($urandom_range(0, 5))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'h0000_0000;
            3:       v = 32'h0000_0001;
            4:       v = 32'hFFFF_FFFF;
            default: v = 32'h8000_0001;
         endcase
      end
      return v;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      logic [31:0] corner_words [15];
      logic [31:0] wide_words   [3];
      int unsigned cfg_plan     [8];

      // Zero, smallest steps, format limits, +-1, +-pi/2, +-pi, +-4 and
      // alternating bit patterns. At the reset term count, +-8 overshoot the
      // format and saturate.
      corner_words = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                       32'h7FFF_FFFF, 32'h8000_0000, Q_ONE, -Q_ONE,
                       Q_HALF_PI, -Q_HALF_PI, Q_PI, -Q_PI,
                       32'h4000_0000, 32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
      wide_words   = '{32'h7FFF_FFFF, 32'h8000_0000, Q_HALF_PI};
      // Covers the zero-term case, the full count, a count above the limit
      // (all register bits set) and a few in between.
      cfg_plan     = '{MAX_TERMS, 15, 1, 5, 0, 12, 2, $urandom_range(0, 15)};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset term count.
      foreach (corner_words[i]) begin
         send_word(corner_words[i], (i % 4 == 3) || (i == 14));
      end

      // Term count above MAX_TERMS acts as MAX_TERMS.
      set_terms(4'd9);
      foreach (wide_words[i]) begin
         send_word(wide_words[i], i == 2);
      end

      // Bare x: -8 lands exactly on the lower limit.
      set_terms(4'd0);
      foreach (wide_words[i]) begin
         send_word(wide_words[i], i == 2);
      end

      // Random part: three phases for each of the first two idle regimes, two
      // without idling; the first of those also carries the long output hold-off.
      for (int p = 0; p < 8; p++) begin
         set_terms(cfg_plan[p][CSR_W-1:0]);
         if (p < 3) begin
            send_idle_pct = 7;
            rcv_idle_pct  = 50;
         end else if (p < 6) begin
            send_idle_pct = 50;
            rcv_idle_pct  = 7;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         if (p == 6) begin
            hold_asks = hold_asks + 1;
         end
         repeat (PHASE_WORDS) begin
            send_word(pick_angle(), $urandom_range(0, 7) == 0);
         end
      end

      drain_pipe();
      if (trk.bad_count == 0 && trk.owed() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
src/stu_pkg.sv
src/sine_taylor_series_unit.sv
src/stu_checker.sv
tb/sine_taylor_series_unit_tb.sv
